/* hdl/rmf_pkg.sv */
// ----------------------------------------------------------------------------
// Running median filter package
// Item types shared by the front queue, the median engine and the top level.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int SampleWidth = 32;
   localparam int HalfWidth   = 4;
   localparam int ResultWidth = 5;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] median;
      logic                          run_last;
      logic                          signal_end;
   } rsp_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample;
      logic                          fill;
      logic                          last;
      logic [HalfWidth-1:0]          half;
      logic [HalfWidth-1:0]          pads;
      logic [ResultWidth-1:0]        nres;
   } job_type;

endpackage

/* hdl/rmf_front.sv */
// ----------------------------------------------------------------------------
// Running median filter front end
// Accepts samples, tracks the signal position and queues one job per item.
// ----------------------------------------------------------------------------
module rmf_front #(
   parameter int MAX_HALF_WINDOW = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rmf_pkg::req_type                    req_payload,
   input  logic [rmf_pkg::HalfWidth-1:0]       half_eff,
   output logic                                q_valid,
   output rmf_pkg::job_type                    q_entry,
   input  logic                                q_pop
);
   import rmf_pkg::*;

   localparam int RcWidth = $clog2(MAX_HALF_WINDOW + 2);

   logic [RcWidth-1:0] rc_ff, rc_in, rc_eff;
   logic               in_signal_ff, in_signal_in;
   job_type            q_ff [2];
   job_type            job;
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               accept;
   logic               rc_small;
   logic [HalfWidth-1:0] m;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = q_ff[rd_ptr_ff];

   always_comb begin
      rc_eff   = in_signal_ff ? rc_ff : '0;
      rc_small = int'(rc_eff) < int'(half_eff);
      m        = rc_small ? HalfWidth'(rc_eff) : half_eff;
      job.sample = req_payload.sample;
      job.fill   = !in_signal_ff;
      job.last   = req_payload.last_sample;
      job.half   = half_eff;
      rc_in        = rc_ff;
      in_signal_in = in_signal_ff;
      if (req_payload.last_sample) begin
         job.pads     = half_eff - m;
         job.nres     = ResultWidth'(m) + ResultWidth'(1);
         rc_in        = '0;
         in_signal_in = 1'b0;
      end else begin
         job.pads     = '0;
         job.nres     = rc_small ? '0 : ResultWidth'(1);
         rc_in        = (int'(rc_eff) < MAX_HALF_WINDOW) ? rc_eff + RcWidth'(1) : rc_eff;
         in_signal_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff        <= '0;
         in_signal_ff <= 1'b0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         if (accept) begin
            rc_ff            <= rc_in;
            in_signal_ff     <= in_signal_in;
            q_ff[wr_ptr_ff]  <= job;
            wr_ptr_ff        <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(accept) - 2'(q_pop);
      end
   end

endmodule

/* hdl/rmf_back.sv */
// ----------------------------------------------------------------------------
// Running median filter median engine
// Holds the sample window and finds each median by ranking one candidate
// at a time against the active entries of the window.
// ----------------------------------------------------------------------------
module rmf_back #(
   parameter int MAX_HALF_WINDOW = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  rmf_pkg::job_type q_entry,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rmf_pkg::rsp_type rsp_payload
);
   import rmf_pkg::*;

   localparam int Depth = 2 * MAX_HALF_WINDOW + 1;
   localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_CMP, ST_CNT, ST_EMIT} state_type;

   state_type                     state_ff, state_in;
   logic signed [SampleWidth-1:0] win_ff [Depth];
   logic signed [SampleWidth-1:0] win_in [Depth];
   job_type                       cur_ff, cur_in;
   logic [IdxW-1:0]               idx_ff, idx_in;
   logic [HalfWidth-1:0]          pads_ff, pads_in;
   logic [ResultWidth-1:0]        rem_ff, rem_in;
   logic [Depth-1:0]              lt_ff, lt_in, le_ff, le_in;
   logic signed [SampleWidth-1:0] cand_ff, cand_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;
   logic [CntW-1:0]               nlt, nle;
   logic                          found;
   logic                          do_shift, do_fill;
   logic signed [SampleWidth-1:0] shift_val;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      nlt   = CntW'($countones(lt_ff));
      nle   = CntW'($countones(le_ff));
      found = (int'(nlt) <= int'(cur_ff.half)) && (int'(nle) > int'(cur_ff.half));
      cand_in = win_ff[idx_ff];
      for (int k = 0; k < Depth; k++) begin
         lt_in[k] = (k <= 2 * int'(cur_ff.half)) && (win_ff[k] <  cand_in);
         le_in[k] = (k <= 2 * int'(cur_ff.half)) && (win_ff[k] <= cand_in);
      end

      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      pads_in      = pads_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      do_shift     = 1'b0;
      do_fill      = 1'b0;
      shift_val    = cur_ff.sample;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cur_in    = q_entry;
               shift_val = q_entry.sample;
               do_fill   = q_entry.fill;
               do_shift  = !q_entry.fill;
               pads_in   = q_entry.pads;
               rem_in    = q_entry.nres;
               idx_in    = '0;
               if (q_entry.pads != '0) begin
                  state_in = ST_PAD;
               end else if (q_entry.nres != '0) begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_PAD: begin
            do_shift = 1'b1;
            pads_in  = pads_ff - HalfWidth'(1);
            if (pads_ff == HalfWidth'(1)) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_CNT;
         end
         ST_CNT: begin
            if (found) begin
               state_in = ST_EMIT;
            end else begin
               idx_in   = idx_ff + IdxW'(1);
               state_in = ST_CMP;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.median     = cand_ff;
               rsp_in.run_last   = (rem_ff == ResultWidth'(1));
               rsp_in.signal_end = (rem_ff == ResultWidth'(1)) && cur_ff.last;
               rem_in            = rem_ff - ResultWidth'(1);
               idx_in            = '0;
               if (rem_ff == ResultWidth'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  do_shift = 1'b1;
                  state_in = ST_CMP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      for (int k = 0; k < Depth; k++) begin
         if (do_fill || (do_shift && k == 0)) begin
            win_in[k] = shift_val;
         end else if (do_shift) begin
            win_in[k] = win_ff[(k > 0) ? k - 1 : 0];
         end else begin
            win_in[k] = win_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      pads_ff <= pads_in;
      rem_ff  <= rem_in;
      lt_ff   <= lt_in;
      le_ff   <= le_in;
      cand_ff <= cand_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/running_median_filter.sv */
// ----------------------------------------------------------------------------
// Running median filter
// Streaming median over a window of 2*half_window+1 samples.
// ----------------------------------------------------------------------------
// Samples enter on the req channel one item at a time; the item marked
// last_sample ends the signal and flushes the remaining medians. Results
// leave on the rsp channel in position order, run_last on the last result
// of each input item and signal_end on the final result of the signal.
// The csr channel writes half_window and is always ready; write it only
// while the block is idle. Values above MAX_HALF_WINDOW act as that value.
// A two-entry queue decouples intake from the median engine. The engine
// takes a job from the queue and adds H-m padding shifts for a final
// sample, where m is the flushed count. It then ranks one window entry
// at a time against the active 2*H+1 entries of the window, in a compare
// state and a count state, until the median is found, and loads it into
// the result register. An item that gives no result only enters the
// window. Reset empties the queue, drops any pending result and starts
// a new signal with half_window = 1.
// While rsp_stall holds a valid result, the result register keeps it and
// the engine waits to emit, and the queue fills until req_stall rises.
// ----------------------------------------------------------------------------
module running_median_filter #(
   parameter int MAX_HALF_WINDOW = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rmf_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rmf_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rmf_pkg::HalfWidth-1:0] csr_data
);
   import rmf_pkg::*;

   logic [HalfWidth-1:0] half_window_ff;
   logic [HalfWidth-1:0] half_eff;
   logic                 q_valid, q_pop;
   job_type              q_entry;

   assign csr_ready = 1'b1;
   assign half_eff  = (int'(half_window_ff) > MAX_HALF_WINDOW) ?
                      HalfWidth'(MAX_HALF_WINDOW) : half_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff <= HalfWidth'(1);
      end else if (csr_valid && csr_ready) begin
         half_window_ff <= csr_data;
      end
   end

   rmf_front #(.MAX_HALF_WINDOW(MAX_HALF_WINDOW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .half_eff    (half_eff),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   rmf_back #(.MAX_HALF_WINDOW(MAX_HALF_WINDOW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_end_is_run_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.signal_end |-> rsp_payload.run_last)
      else $error("signal_end without run_last");

   a_reset_empties : assert property (@(posedge clock)
      $past(reset) |-> !req_stall && !rsp_valid)
      else $error("queue or result not cleared by reset");

   a_pop_needs_item : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("engine popped an empty queue");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Running median filter testbench
// Drives sample signals of many lengths and window settings with random gaps
// and result stalls, predicts every median, and checks each result in order.
// ----------------------------------------------------------------------------
module testbench;
   import rmf_pkg::*;

   localparam int MaxHalf = 15;
   localparam int Depth   = 2 * MaxHalf + 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [HalfWidth-1:0] csr_data = '0;

   running_median_filter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   req_type pending_samples[$];
   rsp_type expected_medians[$];

   logic signed [SampleWidth-1:0] window[Depth];
   int   seen_count = 0;
   logic in_signal = 1'b0;
   int   half_setting = 1;

   logic req_took = 1'b0;
   int   req_gap = 0;
   int   stall_left = 0;
   logic hold = 1'b0;
   logic quiet = 1'b0;
   int   errors = 0;
   int   items_sent = 0;
   int   medians_seen = 0;
   int   signals_sent = 0;

   function automatic logic signed [SampleWidth-1:0] window_median(int h);
      logic signed [SampleWidth-1:0] srt[Depth];
      logic signed [SampleWidth-1:0] v;
      int j;
      for (int i = 0; i < 2 * h + 1; i++) begin
         v = window[i];
         j = i;
         while (j > 0 && srt[j-1] > v) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = v;
      end
      return srt[h];
   endfunction

   function automatic void shift_window(logic signed [SampleWidth-1:0] s);
      for (int i = Depth - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = s;
   endfunction

   function automatic void push_median(int h, logic rl, logic se);
      rsp_type r;
      r.median = window_median(h);
      r.run_last = rl;
      r.signal_end = se;
      expected_medians.push_back(r);
   endfunction

   function automatic void predict_medians(req_type it);
      int h;
      int m;
      h = (half_setting > MaxHalf) ? MaxHalf : half_setting;
      if (!in_signal) begin
         for (int i = 0; i < Depth; i++) window[i] = it.sample;
         seen_count = 0;
         in_signal = 1'b1;
      end else begin
         shift_window(it.sample);
      end
      if (!it.last_sample) begin
         if (seen_count >= h) push_median(h, 1'b1, 1'b0);
         if (seen_count < MaxHalf) seen_count++;
      end else begin
         m = (seen_count < h) ? seen_count : h;
         for (int i = 0; i < h - m; i++) shift_window(it.sample);
         push_median(h, m == 0, m == 0);
         for (int i = 0; i < m; i++) begin
            shift_window(it.sample);
            push_median(h, i + 1 == m, i + 1 == m);
         end
         in_signal = 1'b0;
         seen_count = 0;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_medians(req_payload);
            items_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            medians_seen++;
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected result, actual median %0d run_last %0b signal_end %0b",
                        $time, rsp_payload.median, rsp_payload.run_last,
                        rsp_payload.signal_end);
               errors++;
            end else begin
               rsp_type e;
               e = expected_medians.pop_front();
               if (e.median !== rsp_payload.median) begin
                  $display("%0t: median mismatch, expected %0d actual %0d", $time,
                           e.median, rsp_payload.median);
                  errors++;
               end
               if (e.run_last !== rsp_payload.run_last) begin
                  $display("%0t: run_last mismatch, expected %0b actual %0b", $time,
                           e.run_last, rsp_payload.run_last);
                  errors++;
               end
               if (e.signal_end !== rsp_payload.signal_end) begin
                  $display("%0t: signal_end mismatch, expected %0b actual %0b", $time,
                           e.signal_end, rsp_payload.signal_end);
                  errors++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid = 1'b0;
         rsp_stall = 1'b0;
      end else begin
         if (!req_valid || req_took) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid = 1'b0;
            end else if (!hold && pending_samples.size() > 0) begin
               req_payload = pending_samples.pop_front();
               req_valid = 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 9);
            end else begin
               req_valid = 1'b0;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
         end
      end
   end

   task automatic add_item(logic signed [SampleWidth-1:0] s, logic last);
      req_type it;
      it.sample = s;
      it.last_sample = last;
      pending_samples.push_back(it);
      if (last) signals_sent++;
   endtask

   task automatic add_signal(int len);
      int mode;
      logic signed [SampleWidth-1:0] s;
      mode = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
         case (mode)
            0: s = $urandom;
            1: s = $signed($urandom_range(0, 20)) - 10;
            2: begin
               case ($urandom_range(0, 3))
                  0: s = 32'sh8000_0000;
                  1: s = 32'sh7fff_ffff;
                  2: s = 32'sh0000_0000;
                  default: s = -32'sd1;
               endcase
            end
            default: s = (k % 3 == 0) ? $urandom : $signed($urandom_range(0, 4)) << 16;
         endcase
         add_item(s, k == len - 1);
      end
   endtask

   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_valid || expected_medians.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_half(int v);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = v[HalfWidth-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      half_setting = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_phase(int h, int items, int max_len);
      int n;
      int len;
      wait_idle();
      write_half(h);
      n = 0;
      while (n < items) begin
         len = $urandom_range(1, max_len);
         add_signal(len);
         n += len;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Window of three at reset: single-sample signals, a short flush and extremes.
      add_item(32'sh8000_0000, 1'b1);
      add_item(32'sh7fff_ffff, 1'b1);
      add_item(32'sh7fff_ffff, 1'b0);
      add_item(32'sh8000_0000, 1'b1);
      add_item(32'sh8000_0000, 1'b0);
      add_item(32'sh7fff_ffff, 1'b0);
      add_item(32'sh0000_0000, 1'b0);
      add_item(-32'sd1, 1'b0);
      add_item(32'sh0001_0000, 1'b1);
      wait_idle();
      write_half(0);
      add_item(32'sh1234_5678, 1'b0);
      add_item(-32'sd5, 1'b0);
      add_item(32'sh7fff_ffff, 1'b1);
      wait_idle();
      write_half(15);
      add_item(32'sh0000_0003, 1'b1);
      for (int k = 0; k < 9; k++) add_item($urandom, k == 8);

      random_phase(2, 40, 12);
      while (pending_samples.size() > 20) @(posedge clock);
      hold = 1'b1;
      @(posedge clock);
      while (expected_medians.size() > 0 || req_valid) @(posedge clock);
      hold = 1'b0;
      random_phase(15, 40, 36);
      random_phase(0, 30, 6);
      random_phase(7, 40, 20);
      random_phase(4, 40, 14);
      random_phase(1, 30, 8);
      wait_idle();
      quiet = 1'b1;
      random_phase(3, 40, 10);
      wait_idle();

      $display("Sent %0d samples in %0d signals over half widths 0 to 15.",
               items_sent, signals_sent);
      $display("Checked %0d medians with random gaps and result stalls.", medians_seen);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timeout with %0d results outstanding.", expected_medians.size());
      $display("testbench NOT OK");
      $finish;
   end

endmodule
